/* rtl/vtm_pkg.sv */
// ----------------------------------------------------------------------------
// vtm_pkg
// Shared types and constants of the vibration trend monitor.
// ----------------------------------------------------------------------------
package vtm_pkg;

    localparam int WINDOW_DEF = 30;
    localparam int RECENT_DEF = 10;

    localparam int SAMPLE_W = 16;
    localparam int LIMIT_W  = 23;
    localparam int SLOPE_W  = 24;
    localparam int HOURS_W  = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 23;

    localparam int DIV_N = 40;
    localparam int DIV_D = 24;

    localparam logic [SAMPLE_W-1:0] CRIT_RST  = 16'd8192;
    localparam logic [SAMPLE_W-1:0] WARN_RST  = 16'd4096;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST = 23'd655;
    localparam logic [SAMPLE_W-1:0] FILL_RST  = 16'd2048;

    localparam logic [SLOPE_W-1:0] SLOPE_POS_MAX = 24'h7FFFFF;
    localparam logic [SLOPE_W-1:0] SLOPE_NEG_MAX = 24'h800000;
    localparam logic [HOURS_W-1:0] HOURS_UNKNOWN = 10'd999;
    localparam logic [HOURS_W-1:0] HOURS_SAT     = 10'd998;
    localparam int HOURS_SCALE = 384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CRITICAL = 2'd0,
        REG_WARNING  = 2'd1,
        REG_LIMIT    = 2'd2,
        REG_FILL     = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_OLD, ST_RD_DROP, ST_UPD,
        ST_BASE, ST_REC, ST_NUM1, ST_NUM2,
        ST_SLP_LO, ST_SLP_HI, ST_SLP_SUM, ST_SLP_SAT,
        ST_DIVH_S, ST_DIVH_W, ST_FIN
    } t_state;

endpackage

/* rtl/vibration_trend_monitor_unit.sv */
// ----------------------------------------------------------------------------
// vibration_trend_monitor_unit
// Sliding-window regression slope, recent mean and time-to-critical estimate
// over a ring of vibration samples held in a synchronous memory.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake                | Payload
// sample   | in        | i_valid / i_ready        | i_vibration_sample
// result   | out       | o_valid / o_ready        | o_anomaly .. o_hours_to_critical
// config   | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// An item passes through the serial hours division only when the slope is
// rising. Before the baseline an item skips the slope and hours states; the
// item that latches the baseline also passes through ST_BASE. Divisions by
// constants use reciprocal products.
// Reset and a fill level write mark every ring entry as holding the fill level.
// A new sample is taken while a finished result still waits on the output;
// the next result waits until the output register is free.
// ----------------------------------------------------------------------------
module vibration_trend_monitor_unit #(
    parameter int WINDOW = vtm_pkg::WINDOW_DEF,
    parameter int RECENT = vtm_pkg::RECENT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          i_ready,
    input  logic [vtm_pkg::SAMPLE_W-1:0]  i_vibration_sample,
    output logic                          o_valid,
    input  logic                          o_ready,
    output logic                          o_anomaly,
    output logic                          o_baseline_ready,
    output logic [vtm_pkg::SAMPLE_W-1:0]  o_baseline_level,
    output logic signed [vtm_pkg::SLOPE_W-1:0] o_trend_slope,
    output logic [vtm_pkg::SAMPLE_W-1:0]  o_recent_average,
    output logic [vtm_pkg::HOURS_W-1:0]   o_hours_to_critical,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [vtm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vtm_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int SW   = vtm_pkg::SAMPLE_W;
    localparam int RC   = (RECENT < WINDOW) ? RECENT : WINDOW;
    localparam int PW   = $clog2(WINDOW);
    localparam int SX   = WINDOW * (WINDOW - 1) / 2;
    localparam int DEN  = WINDOW * WINDOW * (WINDOW * WINDOW - 1) / 12;
    localparam int S_W  = SW + $clog2(WINDOW + 1);
    localparam int X_W  = SW + $clog2(SX + 1);
    localparam int R_W  = SW + $clog2(RC + 1);
    localparam int N_W  = X_W + $clog2(WINDOW + 1) + 1;
    localparam int DROP = WINDOW - RC;
    localparam int DN   = vtm_pkg::DIV_N;
    localparam int DD   = vtm_pkg::DIV_D;
    localparam int XN   = N_W + 4;
    localparam int XL   = XN / 2;
    localparam int XH   = XN - XL;
    localparam int KB   = S_W + $clog2(WINDOW);
    localparam int KR   = R_W + $clog2(RC);
    localparam int KS   = XN + $clog2(DEN);
    localparam logic [63:0] MB = ((64'd1 << KB) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [63:0] MR = ((64'd1 << KR) + 64'(RC) - 64'd1) / 64'(RC);
    localparam logic [63:0] MS = ((64'd1 << KS) + 64'(DEN) - 64'd1) / 64'(DEN);

    vtm_pkg::t_state r_state, n_state;

    logic [SW-1:0] r_crit, r_warn, r_fill;
    logic [vtm_pkg::LIMIT_W-1:0] r_limit;

    logic [SW-1:0] r_mem [WINDOW];
    logic [WINDOW-1:0] r_vld;
    logic [SW-1:0] r_rd_data;
    logic          r_rd_vld;
    logic [PW-1:0] rd_addr;
    logic [SW-1:0] rd_val;
    logic          mem_we;

    logic [PW-1:0]  r_wp, wp_next;
    logic [PW:0]    drop_sum;
    logic [S_W-1:0] r_s;
    logic [X_W-1:0] r_x;
    logic [R_W-1:0] r_r;
    logic [SW-1:0]  r_cur, r_old, r_base, r_rec;
    logic           r_flag;
    logic [N_W-1:0] r_p1, r_p2, diff;
    logic [N_W-1:0] r_mag;
    logic           r_neg;
    logic signed [vtm_pkg::SLOPE_W-1:0] r_slope, slope_sat;
    logic [vtm_pkg::HOURS_W-1:0] r_hours;

    logic [2*S_W+1:0] base_prod;
    logic [2*R_W+1:0] rec_prod;
    logic [XN-1:0]    slp_dvd;
    logic [XH-1:0]    slp_half;
    logic [XH+XN+1:0] slp_prod, r_plo, r_phi;
    logic [2*XN+1:0]  slp_sum;
    logic [DN-1:0]    r_sq;

    logic          r_ovalid, r_o_anom, r_o_flag;
    logic [SW-1:0] r_o_base, r_o_rec;
    logic signed [vtm_pkg::SLOPE_W-1:0] r_o_slope;
    logic [vtm_pkg::HOURS_W-1:0] r_o_hours;

    logic          div_start, div_busy, div_done;
    logic [DN-1:0] div_dividend, div_q;
    logic [DD-1:0] div_divisor;
    logic [SW-1:0] margin;
    logic          cfg_fill, in_acc, out_load, anom;

    assign o_cfg_ready = 1'b1;
    assign cfg_fill = i_cfg_valid && (i_cfg_index == vtm_pkg::REG_FILL);
    assign i_ready  = (r_state == vtm_pkg::ST_IDLE);
    assign in_acc   = i_valid && i_ready;

    assign wp_next  = (r_wp == PW'(WINDOW - 1)) ? '0 : r_wp + 1'b1;
    assign drop_sum = {1'b0, r_wp} + (PW + 1)'(DROP);
    assign rd_val   = r_rd_vld ? r_rd_data : r_fill;
    assign mem_we   = (r_state == vtm_pkg::ST_UPD);

    always_comb begin
        case (r_state)
            vtm_pkg::ST_RD_OLD, vtm_pkg::ST_RD_DROP:
                rd_addr = (drop_sum >= (PW + 1)'(WINDOW)) ?
                          PW'(drop_sum - (PW + 1)'(WINDOW)) : drop_sum[PW-1:0];
            default: rd_addr = r_wp;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= r_cur;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_fill) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (mem_we) begin
                r_vld[r_wp] <= 1'b1;
            end
            r_rd_vld <= r_vld[rd_addr];
        end
    end

    assign diff   = r_p1 - r_p2;
    assign margin = (r_crit > r_cur) ? r_crit - r_cur : '0;

    assign base_prod = (2*S_W+2)'(r_s) * (2*S_W+2)'(MB[S_W+1:0]);
    assign rec_prod  = (2*R_W+2)'(r_r) * (2*R_W+2)'(MR[R_W+1:0]);
    assign slp_dvd   = {r_mag, 4'b0000};
    assign slp_half  = (r_state == vtm_pkg::ST_SLP_HI) ? slp_dvd[XN-1:XL] :
                       XH'(slp_dvd[XL-1:0]);
    assign slp_prod  = (XH+XN+2)'(slp_half) * (XH+XN+2)'(MS[XN+1:0]);
    assign slp_sum   = {r_phi, {XL{1'b0}}} + (2*XN+2)'(r_plo);

    always_comb begin
        if (!r_neg) begin
            slope_sat = (r_sq > DN'(vtm_pkg::SLOPE_POS_MAX)) ?
                        vtm_pkg::SLOPE_POS_MAX : r_sq[vtm_pkg::SLOPE_W-1:0];
        end else begin
            slope_sat = (r_sq > DN'(vtm_pkg::SLOPE_NEG_MAX)) ?
                        vtm_pkg::SLOPE_NEG_MAX : -r_sq[vtm_pkg::SLOPE_W-1:0];
        end
    end

    assign div_start    = (r_state == vtm_pkg::ST_DIVH_S);
    assign div_dividend = DN'(DN'(margin) * DN'(vtm_pkg::HOURS_SCALE));
    assign div_divisor  = DD'(r_slope);

    vtm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign out_load = (r_state == vtm_pkg::ST_FIN) && (!r_ovalid || o_ready);
    assign anom = r_flag && ((r_cur > r_crit) ||
                  ((r_rec > r_warn) &&
                   (r_slope > $signed({1'b0, r_limit}))));

    always_comb begin
        n_state = r_state;
        case (r_state)
            vtm_pkg::ST_IDLE:    if (i_valid) n_state = vtm_pkg::ST_RD_OLD;
            vtm_pkg::ST_RD_OLD:  n_state = vtm_pkg::ST_RD_DROP;
            vtm_pkg::ST_RD_DROP: n_state = vtm_pkg::ST_UPD;
            vtm_pkg::ST_UPD: begin
                n_state = (!r_flag && wp_next == '0) ?
                          vtm_pkg::ST_BASE : vtm_pkg::ST_REC;
            end
            vtm_pkg::ST_BASE:    n_state = vtm_pkg::ST_REC;
            vtm_pkg::ST_REC:     n_state = r_flag ? vtm_pkg::ST_NUM1 : vtm_pkg::ST_FIN;
            vtm_pkg::ST_NUM1:    n_state = vtm_pkg::ST_NUM2;
            vtm_pkg::ST_NUM2:    n_state = vtm_pkg::ST_SLP_LO;
            vtm_pkg::ST_SLP_LO:  n_state = vtm_pkg::ST_SLP_HI;
            vtm_pkg::ST_SLP_HI:  n_state = vtm_pkg::ST_SLP_SUM;
            vtm_pkg::ST_SLP_SUM: n_state = vtm_pkg::ST_SLP_SAT;
            vtm_pkg::ST_SLP_SAT: begin
                n_state = (slope_sat > 0) ? vtm_pkg::ST_DIVH_S : vtm_pkg::ST_FIN;
            end
            vtm_pkg::ST_DIVH_S:  n_state = vtm_pkg::ST_DIVH_W;
            vtm_pkg::ST_DIVH_W:  if (div_done) n_state = vtm_pkg::ST_FIN;
            vtm_pkg::ST_FIN:     if (out_load) n_state = vtm_pkg::ST_IDLE;
            default:             n_state = vtm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vtm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crit  <= vtm_pkg::CRIT_RST;
            r_warn  <= vtm_pkg::WARN_RST;
            r_limit <= vtm_pkg::LIMIT_RST;
            r_fill  <= vtm_pkg::FILL_RST;
            r_wp    <= '0;
            r_s     <= S_W'(WINDOW * int'(vtm_pkg::FILL_RST));
            r_x     <= X_W'(SX * int'(vtm_pkg::FILL_RST));
            r_r     <= R_W'(RC * int'(vtm_pkg::FILL_RST));
            r_base  <= vtm_pkg::FILL_RST;
            r_flag  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vtm_pkg::REG_CRITICAL: r_crit  <= i_cfg_data[SW-1:0];
                vtm_pkg::REG_WARNING:  r_warn  <= i_cfg_data[SW-1:0];
                vtm_pkg::REG_LIMIT:    r_limit <= i_cfg_data;
                vtm_pkg::REG_FILL: begin
                    r_fill <= i_cfg_data[SW-1:0];
                    r_wp   <= '0;
                    r_s    <= S_W'(S_W'(i_cfg_data[SW-1:0]) * S_W'(WINDOW));
                    r_x    <= X_W'(X_W'(i_cfg_data[SW-1:0]) * X_W'(SX));
                    r_r    <= R_W'(R_W'(i_cfg_data[SW-1:0]) * R_W'(RC));
                    r_base <= i_cfg_data[SW-1:0];
                    r_flag <= 1'b0;
                end
                default: begin
                end
            endcase
        end else if (r_state == vtm_pkg::ST_UPD) begin
            r_wp <= wp_next;
            r_s  <= r_s - S_W'(r_old) + S_W'(r_cur);
            r_x  <= r_x - X_W'(r_s - S_W'(r_old)) + X_W'(X_W'(r_cur) * X_W'(WINDOW - 1));
            r_r  <= r_r - R_W'(rd_val) + R_W'(r_cur);
            if (!r_flag && wp_next == '0) begin
                r_flag <= 1'b1;
            end
        end else if (r_state == vtm_pkg::ST_BASE) begin
            r_base <= base_prod[KB +: SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur <= i_vibration_sample;
        end
        case (r_state)
            vtm_pkg::ST_RD_OLD: r_old <= rd_val;
            vtm_pkg::ST_UPD: begin
                r_slope <= '0;
                r_hours <= vtm_pkg::HOURS_UNKNOWN;
            end
            vtm_pkg::ST_REC: r_rec <= rec_prod[KR +: SW];
            vtm_pkg::ST_NUM1: begin
                r_p1 <= N_W'(N_W'(r_x) * N_W'(WINDOW));
                r_p2 <= N_W'(N_W'(r_s) * N_W'(SX));
            end
            vtm_pkg::ST_NUM2: begin
                r_neg <= diff[N_W-1];
                r_mag <= diff[N_W-1] ? -diff : diff;
            end
            vtm_pkg::ST_SLP_LO:  r_plo <= slp_prod;
            vtm_pkg::ST_SLP_HI:  r_phi <= slp_prod;
            vtm_pkg::ST_SLP_SUM: r_sq <= DN'(slp_sum[2*XN+1:KS]);
            vtm_pkg::ST_SLP_SAT: r_slope <= slope_sat;
            vtm_pkg::ST_DIVH_W: begin
                if (div_done) begin
                    r_hours <= (div_q > DN'(vtm_pkg::HOURS_SAT)) ?
                               vtm_pkg::HOURS_SAT : div_q[vtm_pkg::HOURS_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_anom  <= anom;
            r_o_flag  <= r_flag;
            r_o_base  <= r_base;
            r_o_slope <= r_slope;
            r_o_rec   <= r_rec;
            r_o_hours <= r_hours;
        end
    end

    assign o_valid             = r_ovalid;
    assign o_anomaly           = r_o_anom;
    assign o_baseline_ready    = r_o_flag;
    assign o_baseline_level    = r_o_base;
    assign o_trend_slope       = r_o_slope;
    assign o_recent_average    = r_o_rec;
    assign o_hours_to_critical = r_o_hours;

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= PW'(WINDOW - 1))
        else $error("Write pointer left the ring.");

    a_flag_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_flag) |-> $past(cfg_fill))
        else $error("Baseline flag cleared without a fill level write.");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("Divider started while busy.");

    a_no_base_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_baseline_ready) |->
        (o_trend_slope == '0 && o_hours_to_critical == vtm_pkg::HOURS_UNKNOWN
         && !o_anomaly))
        else $error("Trend result reported before the baseline.");

endmodule

/* rtl/vtm_div.sv */
// ----------------------------------------------------------------------------
// vtm_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vtm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [vtm_pkg::DIV_N-1:0]  i_dividend,
    input  logic [vtm_pkg::DIV_D-1:0]  i_divisor,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [vtm_pkg::DIV_N-1:0]  o_quotient
);

    localparam int N = vtm_pkg::DIV_N;
    localparam int D = vtm_pkg::DIV_D;
    localparam int CW = $clog2(N);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [D-1:0]  r_rem;
    logic [D-1:0]  r_dvs;
    logic [N-1:0]  r_quo;
    logic [D:0]    trial;
    logic          fits;

    assign trial = {r_rem, r_quo[N-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? D'(trial - {1'b0, r_dvs}) : trial[D-1:0];
            r_quo <= {r_quo[N-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vibration trend monitor testbench
// Drives vibration samples through the valid/ready channel, predicts slope,
// recent mean, baseline, anomaly flag and hours to critical for each transfer,
// and compares every result transfer against the oldest prediction. Register
// settings are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    import vtm_pkg::*;

    localparam int WIN = WINDOW_DEF;
    localparam int RCNT = (RECENT_DEF < WINDOW_DEF) ? RECENT_DEF : WINDOW_DEF;

    typedef struct packed {
        logic                       anomaly;
        logic                       base_rdy;
        logic [SAMPLE_W-1:0]        base_lvl;
        logic signed [SLOPE_W-1:0]  slope;
        logic [SAMPLE_W-1:0]        recent;
        logic [HOURS_W-1:0]         hours;
    } t_trend;

    class trend_scoreboard;
        logic [SAMPLE_W-1:0] crit_lvl, warn_lvl, fill_lvl;
        logic [LIMIT_W-1:0]  slope_lim;
        logic [SAMPLE_W-1:0] ring[WIN];
        int                  wr_ptr;
        logic [SAMPLE_W-1:0] base_val;
        bit                  base_flag;
        t_trend              pending_q[$];
        int                  mismatches;
        int                  checked;

        function void restart();
            for (int k = 0; k < WIN; k++) ring[k] = fill_lvl;
            wr_ptr = 0;
            base_val = fill_lvl;
            base_flag = 1'b0;
        endfunction

        function void reset_state();
            crit_lvl = CRIT_RST;
            warn_lvl = WARN_RST;
            slope_lim = LIMIT_RST;
            fill_lvl = FILL_RST;
            mismatches = 0;
            checked = 0;
            restart();
        endfunction

        function void write_reg(t_reg_idx idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                REG_CRITICAL: crit_lvl = val[SAMPLE_W-1:0];
                REG_WARNING:  warn_lvl = val[SAMPLE_W-1:0];
                REG_LIMIT:    slope_lim = val[LIMIT_W-1:0];
                REG_FILL: begin
                    fill_lvl = val[SAMPLE_W-1:0];
                    restart();
                end
                default: begin
                end
            endcase
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] cur);
            longint s, sxy, sr, num, slp, rem, h, sx, sxx, den, v, q;
            t_trend r;
            ring[wr_ptr] = cur;
            wr_ptr = (wr_ptr + 1) % WIN;
            s = 0; sxy = 0; sr = 0;
            for (int k = 0; k < WIN; k++) begin
                v = longint'(ring[(wr_ptr + k) % WIN]);
                s += v;
                sxy += longint'(k) * v;
                if (k >= WIN - RCNT) sr += v;
            end
            if (!base_flag && wr_ptr == 0) begin
                q = s / WIN;
                base_val = q[SAMPLE_W-1:0];
                base_flag = 1'b1;
            end
            q = sr / RCNT;
            r.anomaly = 1'b0;
            r.base_rdy = base_flag;
            r.base_lvl = base_val;
            r.recent = q[SAMPLE_W-1:0];
            r.slope = '0;
            r.hours = HOURS_UNKNOWN;
            if (base_flag) begin
                sx = WIN * (WIN - 1) / 2;
                sxx = (WIN - 1) * WIN * (2 * WIN - 1) / 6;
                den = WIN * sxx - sx * sx;
                num = WIN * sxy - sx * s;
                slp = (num * 16) / den;
                if (slp > 8388607) slp = 8388607;
                if (slp < -8388608) slp = -8388608;
                r.slope = slp[SLOPE_W-1:0];
                if (cur > crit_lvl)
                    r.anomaly = 1'b1;
                else if (r.recent > warn_lvl && slp > longint'(slope_lim))
                    r.anomaly = 1'b1;
                if (slp > 0) begin
                    rem = longint'(crit_lvl) - longint'(cur);
                    if (rem < 0) rem = 0;
                    h = (rem * HOURS_SCALE) / slp;
                    r.hours = (h > 998) ? HOURS_SAT : h[HOURS_W-1:0];
                end
            end
            pending_q.push_back(r);
        endfunction

        function void check_result(t_trend act);
            t_trend exp_r;
            checked++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transfer: %p", act);
                return;
            end
            exp_r = pending_q.pop_front();
            if (exp_r !== act) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch on result %0d:", checked);
                    $display("  expected %p", exp_r);
                    $display("  actual   %p", act);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_valid = 0;
    logic                  i_ready;
    logic [SAMPLE_W-1:0]   i_vibration_sample = '0;
    logic                  o_valid;
    logic                  o_ready = 0;
    logic                  o_anomaly;
    logic                  o_baseline_ready;
    logic [SAMPLE_W-1:0]   o_baseline_level;
    logic signed [SLOPE_W-1:0] o_trend_slope;
    logic [SAMPLE_W-1:0]   o_recent_average;
    logic [HOURS_W-1:0]    o_hours_to_critical;
    logic                  i_cfg_valid = 0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_data = '0;

    trend_scoreboard sb;
    int  samples_sent = 0;
    int  cfg_writes = 0;
    bit  idle_on = 1;
    bit  hold_req = 0;

    vibration_trend_monitor_unit dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        #20ms;
        $display("Timeout waiting for results.");
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int hold_left;
        t_trend act;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && o_ready) begin
                act = {o_anomaly, o_baseline_ready, o_baseline_level, o_trend_slope,
                       o_recent_average, o_hours_to_critical};
                sb.check_result(act);
            end
            if (hold_req && hold_left == 0) begin
                hold_left = 600;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                o_ready <= 0;
            end else if (!i_rst_n) begin
                o_ready <= 0;
            end else begin
                o_ready <= !(idle_on && $urandom_range(99) < 14);
            end
        end
    end

    task automatic send_sample(logic [SAMPLE_W-1:0] v);
        i_valid <= 1;
        i_vibration_sample <= v;
        @(posedge i_clk);
        while (!i_ready) @(posedge i_clk);
        sb.note_sample(v);
        samples_sent++;
        if (idle_on && $urandom_range(99) < 14) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        cfg_writes++;
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic set_all(logic [15:0] crit, logic [15:0] warn, logic [22:0] lim,
                           logic [15:0] fill);
        wait_idle();
        write_reg(REG_CRITICAL, CFG_DAT_W'(crit));
        write_reg(REG_WARNING, CFG_DAT_W'(warn));
        write_reg(REG_LIMIT, lim);
        write_reg(REG_FILL, CFG_DAT_W'(fill));
    endtask

    task automatic random_samples(int count);
        int mode, left, step;
        logic [SAMPLE_W-1:0] v;
        longint lv;
        left = 0;
        mode = 0;
        step = 0;
        lv = 0;
        for (int n = 0; n < count; n++) begin
            if (left == 0) begin
                mode = $urandom_range(4);
                left = $urandom_range(10, 45);
                lv = $urandom_range(65535);
                step = $urandom_range(1, 2500);
                if (mode == 4) lv = longint'(sb.crit_lvl);
            end
            left--;
            case (mode)
                0: lv = $urandom_range(65535);
                1: lv = lv + $urandom_range(step);
                2: lv = lv - $urandom_range(step);
                default: lv = lv + $urandom_range(64) - 32;
            endcase
            if (lv > 65535) lv = 65535;
            if (lv < 0) lv = 0;
            v = lv[SAMPLE_W-1:0];
            send_sample(v);
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Extremes and a rising run, all before the baseline is latched.
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'd8192);
        send_sample(16'd8193);
        for (int k = 0; k < 21; k++) send_sample(16'(k * 600));

        random_samples(90);
        set_all(16'hFFFF, 16'h0000, 23'd0, 16'h0000);
        random_samples(100);
        set_all(16'h0000, 16'hFFFF, 23'h7FFFFF, 16'hFFFF);
        random_samples(100);
        set_all(16'd12000, 16'd3000, 23'd100, 16'd1000);
        idle_on = 0;
        random_samples(90);
        idle_on = 1;
        hold_req = 1;
        random_samples(60);
        set_all(16'($urandom), 16'($urandom), 23'($urandom), 16'($urandom));
        random_samples(100);
        set_all(16'd40000, 16'd20000, 23'd2000, 16'd30000);
        random_samples(100);
        set_all(CRIT_RST, WARN_RST, LIMIT_RST, FILL_RST);
        random_samples(50);

        wait_idle();
        $display("Covered %0d sample transfers and %0d register writes over seven settings,",
                 samples_sent, cfg_writes);
        $display("with random stalls, a long output hold-off and extreme levels.");
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches.", sb.mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
